// ===== hw/rtl/dtne_pkg.sv =====
// ----------------------------------------------------------------------------
// dtne_pkg
// Shared types and constants for the decision trail nogood emitter: field
// widths, operation and status codes, trail entry layout and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dtne_pkg;

    localparam int DTNE_MAX_DEPTH = 32;

    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int VAR_W       = 10;
    localparam int VAL_W       = 8;
    localparam int DEPTH_OUT_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 2'd0,
        OP_REFUTE   = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_GENERATE = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMIT      = 2'd3
    } status_t;

    typedef struct packed {
        logic [VAR_W-1:0] var_id;
        logic [VAL_W-1:0] value_id;
        logic             neg;
    } trail_entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic    latch_in;    // capture operands of the accepted beat
        logic    cnt_clear;   // restart the trail walk at the bottom entry
        logic    push;        // append a positive entry from the input ports
        logic    clear;       // empty the trail
        logic    hit;         // negate the matched entry and cut the trail above it
        logic    rd_issue;    // read the entry at the walk counter
        logic    rd_hold;     // keep the read entry for a stalled output
        logic    load_code;   // load a single-result beat with the code below
        logic    load_entry;  // load the read entry as an emitted beat
        status_t code;
    } dtne_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic scan_end;
        logic rd_valid;
        logic match;
        logic out_free;
        logic entry_last;
    } dtne_stat_t;

endpackage

// ===== hw/rtl/decision_trail_nogood_emitter_core.sv =====
// ----------------------------------------------------------------------------
// decision_trail_nogood_emitter_core
// Decision trail with push, refute, clear and nogood generation over a
// single-port trail memory, one result beat per trail entry on generate.
// ----------------------------------------------------------------------------
// Sequence: push and clear go through the report state into the output
// register; refute searches the trail from the bottom, one entry searched per
// cycle, and reports through the report state; generate loads its beats from
// the read register, one beat per cycle while taken. One operation at a time:
// a new beat is taken only after the last result is loaded into the output.
// Reset empties the trail and the output; trail memory contents are not cleared.
module decision_trail_nogood_emitter_core
    import dtne_pkg::*;
#(
    parameter int MAX_DEPTH = DTNE_MAX_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OP_W-1:0]        opcode,
    input  logic [VAR_W-1:0]       var_index,
    input  logic [VAL_W-1:0]       value_index,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_W-1:0]    status,
    output logic [VAR_W-1:0]       out_var,
    output logic [VAL_W-1:0]       out_value,
    output logic                   negated,
    output logic                   closes_clause,
    output logic [DEPTH_OUT_W-1:0] depth_now,
    output logic                   last
);

    dtne_cmd_t  cmd;
    dtne_stat_t stat;

    dtne_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .stat     (stat),
        .cmd      (cmd)
    );

    dtne_dpath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .var_index     (var_index),
        .value_index   (value_index),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .out_var       (out_var),
        .out_value     (out_value),
        .negated       (negated),
        .closes_clause (closes_clause),
        .depth_now     (depth_now),
        .last          (last)
    );

endmodule

// ===== hw/rtl/dtne_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtne_ctrl
// Controller state machine. Decodes the accepted operation, sequences the
// trail search for refute and the trail walk for generate, and schedules the
// result beats into the output register.
// ----------------------------------------------------------------------------
module dtne_ctrl
    import dtne_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   opcode,
    input  dtne_stat_t        stat,
    output dtne_cmd_t         cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_GEN,
        S_REPORT
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;
    logic    consume;

    assign in_ready = (state_reg == S_IDLE);
    assign consume  = stat.rd_valid && stat.out_free;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        cmd            = '0;
        cmd.code       = code_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    unique case (opcode)
                        OP_PUSH:
                        begin
                            if (stat.full)
                            begin
                                code_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.push  = 1'b1;
                                code_next = ST_DONE;
                            end
                            state_next = S_REPORT;
                        end
                        OP_REFUTE:
                        begin
                            cmd.cnt_clear = 1'b1;
                            state_next    = S_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            code_next  = ST_DONE;
                            state_next = S_REPORT;
                        end
                        default:
                        begin
                            if (stat.empty)
                            begin
                                code_next  = ST_DONE;
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                cmd.cnt_clear = 1'b1;
                                state_next    = S_GEN;
                            end
                        end
                    endcase
                end
            end

            // One entry read per cycle; each read entry is compared the cycle after.
            S_SCAN:
            begin
                priority if (stat.match)
                begin
                    cmd.hit    = 1'b1;
                    code_next  = ST_DONE;
                    state_next = S_REPORT;
                end
                else if (stat.scan_end)
                begin
                    code_next  = ST_NOT_FOUND;
                    state_next = S_REPORT;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                end
            end

            // The read register doubles as a one-entry buffer ahead of the output.
            S_GEN:
            begin
                cmd.load_entry = consume;
                cmd.rd_hold    = stat.rd_valid && !consume;
                cmd.rd_issue   = !stat.scan_end && (!stat.rd_valid || consume);
                if (consume && stat.entry_last)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                if (stat.out_free)
                begin
                    cmd.load_code = 1'b1;
                    state_next    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

// ===== hw/rtl/dtne_dpath.sv =====
// ----------------------------------------------------------------------------
// dtne_dpath
// Datapath: trail memory with one registered port, trail size, walk counter,
// entry compare and the output register.
// ----------------------------------------------------------------------------
module dtne_dpath
    import dtne_pkg::*;
#(
    parameter int MAX_DEPTH = DTNE_MAX_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [VAR_W-1:0]       var_index,
    input  logic [VAL_W-1:0]       value_index,
    input  dtne_cmd_t              cmd,
    output dtne_stat_t             stat,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_W-1:0]    status,
    output logic [VAR_W-1:0]       out_var,
    output logic [VAL_W-1:0]       out_value,
    output logic                   negated,
    output logic                   closes_clause,
    output logic [DEPTH_OUT_W-1:0] depth_now,
    output logic                   last
);

    localparam int IDX_W  = $clog2(MAX_DEPTH);
    localparam int SIZE_W = $clog2(MAX_DEPTH + 1);

    trail_entry_t trail_mem [MAX_DEPTH];

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rd_valid_reg, rd_valid_next;
    trail_entry_t      rd_data_reg;
    logic [VAR_W-1:0]  key_var_reg;
    logic [VAL_W-1:0]  key_val_reg;

    logic              out_valid_reg;
    status_t           status_reg;
    logic [VAR_W-1:0]  out_var_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic              negated_reg;
    logic              closes_reg;
    logic [DEPTH_OUT_W-1:0] depth_reg;
    logic              last_reg;

    logic [SIZE_W-1:0] hit_size;
    logic [SIZE_W+DEPTH_OUT_W-1:0] size_wide;
    logic              load;

    assign hit_size  = SIZE_W'(rd_idx_reg) + SIZE_W'(1);
    assign size_wide = (SIZE_W + DEPTH_OUT_W)'(size_reg);
    assign load      = cmd.load_code || cmd.load_entry;

    assign stat.full       = (size_reg == SIZE_W'(MAX_DEPTH));
    assign stat.empty      = (size_reg == '0);
    assign stat.scan_end   = (cnt_reg == size_reg);
    assign stat.rd_valid   = rd_valid_reg;
    assign stat.match      = rd_valid_reg && !rd_data_reg.neg
                             && (rd_data_reg.var_id == key_var_reg)
                             && (rd_data_reg.value_id == key_val_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.entry_last = (hit_size == size_reg);

    always_comb
    begin
        size_next = size_reg;
        priority if (cmd.clear)
        begin
            size_next = '0;
        end
        else if (cmd.push)
        begin
            size_next = size_reg + SIZE_W'(1);
        end
        else if (cmd.hit)
        begin
            size_next = hit_size;
        end
        else
        begin
            size_next = size_reg;
        end

        priority if (cmd.cnt_clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.rd_issue)
        begin
            cnt_next = cnt_reg + SIZE_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end

        rd_valid_next = cmd.rd_issue || (rd_valid_reg && cmd.rd_hold);
    end

    // Single-port trail memory; a write and a read never fall in the same cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            trail_mem[size_reg[IDX_W-1:0]] <= '{var_id: var_index,
                                                value_id: value_index,
                                                neg: 1'b0};
        end
        else if (cmd.hit)
        begin
            trail_mem[rd_idx_reg] <= '{var_id: rd_data_reg.var_id,
                                       value_id: rd_data_reg.value_id,
                                       neg: 1'b1};
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= trail_mem[cnt_reg[IDX_W-1:0]];
            rd_idx_reg  <= cnt_reg[IDX_W-1:0];
        end
        if (cmd.latch_in)
        begin
            key_var_reg <= var_index;
            key_val_reg <= value_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= '0;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg     <= size_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_entry)
        begin
            status_reg    <= ST_EMIT;
            out_var_reg   <= rd_data_reg.var_id;
            out_value_reg <= rd_data_reg.value_id;
            negated_reg   <= rd_data_reg.neg;
            closes_reg    <= rd_data_reg.neg && (rd_idx_reg != '0);
            depth_reg     <= size_wide[DEPTH_OUT_W-1:0];
            last_reg      <= stat.entry_last;
        end
        else if (cmd.load_code)
        begin
            status_reg    <= cmd.code;
            out_var_reg   <= '0;
            out_value_reg <= '0;
            negated_reg   <= 1'b0;
            closes_reg    <= 1'b0;
            depth_reg     <= size_wide[DEPTH_OUT_W-1:0];
            last_reg      <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign out_var       = out_var_reg;
    assign out_value     = out_value_reg;
    assign negated       = negated_reg;
    assign closes_clause = closes_reg;
    assign depth_now     = depth_reg;
    assign last          = last_reg;

endmodule
